// ----- hw/rtl/dtsd_pkg.sv -----
// ---------------------------------------------------------------------------
// dtsd_pkg
// Types, codes, microcode store and calendar helpers for the date/time block.
// ---------------------------------------------------------------------------
package dtsd_pkg;

   // request and response words
   typedef struct packed {
      logic              mode;
      logic [2:0]        field_select;
      logic signed [7:0] delta;
      logic [7:0]        seconds_reg;
      logic [7:0]        minutes_reg;
      logic [7:0]        hours_reg;
      logic [7:0]        days_reg;
      logic [7:0]        months_reg;
      logic [7:0]        years_reg;
   } req_type;

   typedef struct packed {
      logic [11:0] year_out;
      logic [4:0]  month_out;
      logic [5:0]  day_out;
      logic [5:0]  hour_out;
      logic [6:0]  minute_out;
      logic [6:0]  second_out;
      logic        in_range;
      logic [1:0]  load_status;
   } rsp_type;

   localparam logic        MODE_LOAD    = 1'b0;
   localparam logic [2:0]  FIELD_YEAR   = 3'd0;
   localparam logic [2:0]  FIELD_MONTH  = 3'd1;
   localparam logic [2:0]  FIELD_DAY    = 3'd2;
   localparam logic [2:0]  FIELD_HOUR   = 3'd3;
   localparam logic [2:0]  FIELD_MINUTE = 3'd4;

   localparam logic [1:0]  STATUS_ADJUST   = 2'd0;
   localparam logic [1:0]  STATUS_LOADED   = 2'd1;
   localparam logic [1:0]  STATUS_REFUSED  = 2'd2;

   localparam logic [11:0] YEAR_BASE  = 12'd2000;
   localparam logic [7:0]  YEAR_LAST  = 8'd99;    // 2099
   localparam logic [7:0]  CENTURY_1  = 8'd100;   // 2100, not leap
   localparam logic [7:0]  CENTURY_2  = 8'd200;   // 2200, not leap

   localparam logic [7:0]  OSC_STOP_MASK = 8'h80;
   localparam logic [7:0]  MASK_7  = 8'h7F;
   localparam logic [7:0]  MASK_6  = 8'h3F;
   localparam logic [7:0]  MASK_5  = 8'h1F;

   // microcode
   typedef enum logic [2:0] {
      OP_IDLE, OP_NOP, OP_LOAD, OP_PREP, OP_SUB, OP_WRITE, OP_CLAMP, OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEVER, COND_ALWAYS, COND_ADJUST, COND_NOFIELD
   } cond_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] shamt;
      cond_type   cond;
      logic [3:0] target;
   } uword_type;

   localparam logic [3:0] STEP_IDLE     = 4'd0;
   localparam logic [3:0] STEP_DISPATCH = 4'd1;
   localparam logic [3:0] STEP_LOAD     = 4'd2;
   localparam logic [3:0] STEP_PREP     = 4'd3;
   localparam logic [3:0] STEP_SUB6     = 4'd4;
   localparam logic [3:0] STEP_SUB5     = 4'd5;
   localparam logic [3:0] STEP_SUB4     = 4'd6;
   localparam logic [3:0] STEP_SUB3     = 4'd7;
   localparam logic [3:0] STEP_SUB2     = 4'd8;
   localparam logic [3:0] STEP_SUB1     = 4'd9;
   localparam logic [3:0] STEP_SUB0     = 4'd10;
   localparam logic [3:0] STEP_WRITE    = 4'd11;
   localparam logic [3:0] STEP_CLAMP    = 4'd12;
   localparam logic [3:0] STEP_OUT      = 4'd13;

   function automatic uword_type ucode(input logic [3:0] pc);
      uword_type w;
      w = '{op: OP_IDLE, shamt: 3'd0, cond: COND_ALWAYS, target: STEP_IDLE};
      case (pc)
         STEP_IDLE:     w = '{OP_IDLE,  3'd0, COND_NEVER,   STEP_IDLE};
         STEP_DISPATCH: w = '{OP_NOP,   3'd0, COND_ADJUST,  STEP_PREP};
         STEP_LOAD:     w = '{OP_LOAD,  3'd0, COND_ALWAYS,  STEP_OUT};
         STEP_PREP:     w = '{OP_PREP,  3'd0, COND_NOFIELD, STEP_CLAMP};
         STEP_SUB6:     w = '{OP_SUB,   3'd6, COND_NEVER,   STEP_IDLE};
         STEP_SUB5:     w = '{OP_SUB,   3'd5, COND_NEVER,   STEP_IDLE};
         STEP_SUB4:     w = '{OP_SUB,   3'd4, COND_NEVER,   STEP_IDLE};
         STEP_SUB3:     w = '{OP_SUB,   3'd3, COND_NEVER,   STEP_IDLE};
         STEP_SUB2:     w = '{OP_SUB,   3'd2, COND_NEVER,   STEP_IDLE};
         STEP_SUB1:     w = '{OP_SUB,   3'd1, COND_NEVER,   STEP_IDLE};
         STEP_SUB0:     w = '{OP_SUB,   3'd0, COND_NEVER,   STEP_IDLE};
         STEP_WRITE:    w = '{OP_WRITE, 3'd0, COND_NEVER,   STEP_IDLE};
         STEP_CLAMP:    w = '{OP_CLAMP, 3'd0, COND_NEVER,   STEP_IDLE};
         STEP_OUT:      w = '{OP_OUT,   3'd0, COND_ALWAYS,  STEP_IDLE};
         default:       w = '{OP_IDLE,  3'd0, COND_ALWAYS,  STEP_IDLE};
      endcase
      return w;
   endfunction

   // high nibble times ten plus low nibble, any nibble value
   function automatic logic [7:0] bcd_decode(input logic [7:0] v);
      logic [7:0] hi;
      hi = {4'd0, v[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
   endfunction

   // year is 2000 + yo, so only three offsets sit on a century
   function automatic logic [4:0] month_days(input logic [7:0] yo, input logic [4:0] mon);
      logic leap;
      logic [4:0] d;
      leap = (yo[1:0] == 2'd0) && (yo != CENTURY_1) && (yo != CENTURY_2);
      case (mon)
         5'd2:                      d = leap ? 5'd29 : 5'd28;
         5'd4, 5'd6, 5'd9, 5'd11:   d = 5'd30;
         default:                   d = 5'd31;   // includes invalid months
      endcase
      return d;
   endfunction

endpackage

// ----- hw/rtl/date_time_set_and_decode.sv -----
// ---------------------------------------------------------------------------
// date_time_set_and_decode
// Calendar date/time holder: load from BCD clock registers, field adjust.
// ---------------------------------------------------------------------------
// Request channel req_valid / req_stall / req_word carries one word per item:
// either a load of six BCD clock-chip registers or a signed adjustment of one
// field. Every item gives exactly one word on rsp_valid / rsp_stall /
// rsp_word with the current fields, a range flag and the load status.
// A microcode store steps a small datapath; one item runs at a time and
// req_stall is low only in the idle step.
// Each item passes dispatch and then, for a load, the load step; for an
// adjust of a field, prepare, the seven conditional subtract steps of the
// wrap unit, write and clamp; for an adjust that selects no field, prepare
// and clamp. All end in the output step; the next word is taken in idle.
// The result sits in an output register; if the receiver stalls, it holds
// and the sequencer waits in its output step until that register frees.
// Reset (synchronous) gives 2000-01-01 00:00:00, idle, no result pending.
// ---------------------------------------------------------------------------
module date_time_set_and_decode
   import dtsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic [3:0]  pc_ff, pc_in;
   req_type     req_ff, req_in;
   logic [7:0]  year_ff, year_in;
   logic [4:0]  month_ff, month_in;
   logic [5:0]  day_ff, day_in;
   logic [5:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [12:0] acc_ff, acc_in;
   logic [6:0]  mod_ff, mod_in;
   logic        lo_ff, lo_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   uword_type   uw;
   logic [4:0]  dim;
   logic [7:0]  sel_val;
   logic [6:0]  sel_mod;
   logic        sel_lo;
   logic [13:0] prep_sum;
   logic [12:0] sub_div;
   logic [6:0]  wval;
   logic        take, jump, advance, valid_now;

   assign uw   = ucode(pc_ff);
   assign dim  = month_days(year_ff, month_ff);
   assign take = req_valid && !req_stall;

   // operand and modulus for the selected field
   always_comb begin
      sel_val = 8'd0;
      sel_mod = 7'd1;
      sel_lo  = 1'b0;
      case (req_ff.field_select)
         FIELD_YEAR: begin
            sel_val = year_ff;
            sel_mod = 7'd100;
         end
         FIELD_MONTH: begin
            sel_val = {3'd0, month_ff};
            sel_mod = 7'd12;
            sel_lo  = 1'b1;
         end
         FIELD_DAY: begin
            sel_val = {2'd0, day_ff};
            sel_mod = {2'd0, dim};
            sel_lo  = 1'b1;
         end
         FIELD_HOUR: begin
            sel_val = {2'd0, hour_ff};
            sel_mod = 7'd24;
         end
         FIELD_MINUTE: begin
            sel_val = {1'b0, minute_ff};
            sel_mod = 7'd60;
         end
         default: begin
            sel_val = 8'd0;
         end
      endcase
   end

   // 16 moduli added up front keep the operand positive for the subtract steps
   assign prep_sum = 14'(sel_val) + 14'(req_ff.delta) - 14'(sel_lo) + (14'(sel_mod) << 4);
   assign sub_div  = 13'(mod_ff) << uw.shamt;
   assign wval     = acc_ff[6:0] + 7'(lo_ff);

   assign valid_now = (year_ff <= YEAR_LAST) && (month_ff >= 5'd1) && (month_ff <= 5'd12)
                   && (day_ff >= 6'd1) && (day_ff <= {1'b0, dim})
                   && (hour_ff <= 6'd23) && (minute_ff <= 7'd59) && (second_ff <= 7'd59);

   always_comb begin
      req_in       = req_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      acc_in       = acc_ff;
      mod_in       = mod_ff;
      lo_in        = lo_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      advance      = 1'b1;

      case (uw.op)
         OP_IDLE: begin
            advance = take;
            if (take) begin
               req_in = req_word;
            end
         end
         OP_LOAD: begin
            if ((req_ff.seconds_reg & OSC_STOP_MASK) != 8'd0) begin
               status_in = STATUS_REFUSED;
            end else begin
               second_in = 7'(bcd_decode(req_ff.seconds_reg & MASK_7));
               minute_in = 7'(bcd_decode(req_ff.minutes_reg & MASK_7));
               hour_in   = 6'(bcd_decode(req_ff.hours_reg & MASK_6));
               day_in    = 6'(bcd_decode(req_ff.days_reg & MASK_6));
               month_in  = 5'(bcd_decode(req_ff.months_reg & MASK_5));
               year_in   = bcd_decode(req_ff.years_reg);
               status_in = STATUS_LOADED;
            end
         end
         OP_PREP: begin
            acc_in = prep_sum[12:0];
            mod_in = sel_mod;
            lo_in  = sel_lo;
         end
         OP_SUB: begin
            if (acc_ff >= sub_div) begin
               acc_in = acc_ff - sub_div;
            end
         end
         OP_WRITE: begin
            case (req_ff.field_select)
               FIELD_YEAR:   year_in   = {1'b0, wval};
               FIELD_MONTH:  month_in  = wval[4:0];
               FIELD_DAY:    day_in    = wval[5:0];
               FIELD_HOUR:   hour_in   = wval[5:0];
               FIELD_MINUTE: minute_in = wval;
               default:      year_in   = year_ff;
            endcase
         end
         OP_CLAMP: begin
            if (day_ff > {1'b0, dim}) begin
               day_in = {1'b0, dim};
            end else if (day_ff == 6'd0) begin
               day_in = 6'd1;
            end
            status_in = STATUS_ADJUST;
         end
         OP_OUT: begin
            advance = !rsp_valid_ff || !rsp_stall;
            if (advance) begin
               rsp_valid_in        = 1'b1;
               rsp_in.year_out     = YEAR_BASE + 12'(year_ff);
               rsp_in.month_out    = month_ff;
               rsp_in.day_out      = day_ff;
               rsp_in.hour_out     = hour_ff;
               rsp_in.minute_out   = minute_ff;
               rsp_in.second_out   = second_ff;
               rsp_in.in_range     = valid_now;
               rsp_in.load_status  = status_ff;
            end
         end
         default: begin
            advance = 1'b1;
         end
      endcase

      case (uw.cond)
         COND_ALWAYS:  jump = 1'b1;
         COND_ADJUST:  jump = req_ff.mode != MODE_LOAD;
         COND_NOFIELD: jump = req_ff.field_select > FIELD_MINUTE;
         default:      jump = 1'b0;
      endcase

      if (!advance) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         year_ff      <= 8'd0;
         month_ff     <= 5'd1;
         day_ff       <= 6'd1;
         hour_ff      <= 6'd0;
         minute_ff    <= 7'd0;
         second_ff    <= 7'd0;
         status_ff    <= STATUS_ADJUST;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         status_ff    <= status_in;
      end
      req_ff <= req_in;
      acc_ff <= acc_in;
      mod_ff <= mod_in;
      lo_ff  <= lo_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (pc_ff != STEP_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // an accepted word always goes to dispatch next
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      take |=> pc_ff == STEP_DISPATCH)
      else $error("accepted word did not reach dispatch");

   // a new result is only launched from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == STEP_OUT)
      else $error("result raised outside output step");

   // in_range must agree with the obvious bounds
   a_range_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.in_range) |->
         (rsp_ff.month_out >= 5'd1 && rsp_ff.month_out <= 5'd12
          && rsp_ff.hour_out <= 6'd23 && rsp_ff.day_out >= 6'd1))
      else $error("in_range set with field out of bounds");

   // the day clamp never leaves day zero after an adjust
   a_adjust_day: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.load_status == STATUS_ADJUST) |->
         (rsp_ff.day_out >= 6'd1 && rsp_ff.day_out <= 6'd31))
      else $error("day outside 1..31 after adjust");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Regression bench for the date/time load and adjust block.
// Request words come from a queue and are driven at the falling edge; result
// words are checked at the rising edge against a calendar model kept in the
// bench. Runs directed corner cases, then random traffic under several
// sender/receiver idle mixes, including one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_top;
   import dtsd_pkg::*;

   localparam logic       MODE_ADJUST  = ~MODE_LOAD;
   localparam logic [2:0] FIELD_NONE_A = 3'd5;   // selects that only clamp the day
   localparam logic [2:0] FIELD_NONE_B = 3'd6;
   localparam logic [2:0] FIELD_NONE_C = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   req_type pending_words[$];
   rsp_type calendar_expect[$];

   logic req_taken;
   logic long_hold;
   int   send_idle_pct;
   int   stall_pct;
   int   error_count;

   // calendar state as the bench sees it
   int cal_year_ofs;
   int cal_month;
   int cal_day;
   int cal_hour;
   int cal_minute;
   int cal_second;

   date_time_set_and_decode u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   function automatic int days_in_month(input int year, input int mon);
      bit leap;
      if (mon < 1 || mon > 12) return 31;
      if (mon == 2) begin
         leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
         return leap ? 29 : 28;
      end
      if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
      return 31;
   endfunction

   function automatic int wrap_range(input int v, input int lo, input int hi);
      int n;
      int r;
      n = hi - lo + 1;
      r = (v - lo) % n;
      if (r < 0) r += n;
      return lo + r;
   endfunction

   function automatic int bcd_value(input logic [7:0] v);
      return int'(v[7:4]) * 10 + int'(v[3:0]);
   endfunction

   function automatic logic [7:0] to_bcd(input int n);
      return {4'(n / 10), 4'(n % 10)};
   endfunction

   task automatic calendar_reset();
      cal_year_ofs = 0;
      cal_month    = 1;
      cal_day      = 1;
      cal_hour     = 0;
      cal_minute   = 0;
      cal_second   = 0;
   endtask

   // apply one accepted request word and queue the result it should give
   task automatic advance_calendar(input req_type w);
      rsp_type    r;
      int         d;
      int         dim;
      logic [1:0] status;
      d = int'($signed(w.delta));
      if (w.mode == MODE_LOAD) begin
         if ((w.seconds_reg & OSC_STOP_MASK) != 0) begin
            status = STATUS_REFUSED;
         end else begin
            cal_second   = bcd_value(w.seconds_reg & MASK_7);
            cal_minute   = bcd_value(w.minutes_reg & MASK_7);
            cal_hour     = bcd_value(w.hours_reg & MASK_6);
            cal_day      = bcd_value(w.days_reg & MASK_6);
            cal_month    = bcd_value(w.months_reg & MASK_5);
            cal_year_ofs = bcd_value(w.years_reg);
            status       = STATUS_LOADED;
         end
      end else begin
         case (w.field_select)
            FIELD_YEAR:   cal_year_ofs = wrap_range(cal_year_ofs + d, 0, int'(YEAR_LAST));
            FIELD_MONTH:  cal_month    = wrap_range(cal_month + d, 1, 12);
            FIELD_DAY:    cal_day      = wrap_range(cal_day + d, 1,
                             days_in_month(2000 + cal_year_ofs, cal_month));
            FIELD_HOUR:   cal_hour     = wrap_range(cal_hour + d, 0, 23);
            FIELD_MINUTE: cal_minute   = wrap_range(cal_minute + d, 0, 59);
            default: ;
         endcase
         dim = days_in_month(2000 + cal_year_ofs, cal_month);
         if (cal_day > dim) cal_day = dim;
         if (cal_day < 1) cal_day = 1;
         status = STATUS_ADJUST;
      end
      r.year_out    = 12'(2000 + cal_year_ofs);
      r.month_out   = 5'(cal_month);
      r.day_out     = 6'(cal_day);
      r.hour_out    = 6'(cal_hour);
      r.minute_out  = 7'(cal_minute);
      r.second_out  = 7'(cal_second);
      r.in_range    = (cal_year_ofs <= 99) && (cal_month >= 1) && (cal_month <= 12) &&
                      (cal_day >= 1) &&
                      (cal_day <= days_in_month(2000 + cal_year_ofs, cal_month)) &&
                      (cal_hour <= 23) && (cal_minute <= 59) && (cal_second <= 59);
      r.load_status = status;
      calendar_expect.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [11:0] want_v,
                              input logic [11:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         if (error_count <= 100)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      end
   endtask

   function automatic req_type load_word(input logic [7:0] sec, input logic [7:0] mins,
                                         input logic [7:0] hrs, input logic [7:0] dys,
                                         input logic [7:0] mon, input logic [7:0] yrs);
      req_type w;
      w.mode         = MODE_LOAD;
      w.field_select = 3'($urandom_range(7));
      w.delta        = 8'($urandom_range(255));
      w.seconds_reg  = sec;
      w.minutes_reg  = mins;
      w.hours_reg    = hrs;
      w.days_reg     = dys;
      w.months_reg   = mon;
      w.years_reg    = yrs;
      return w;
   endfunction

   function automatic req_type adjust_word(input logic [2:0] sel, input logic [7:0] amount);
      req_type w;
      w              = req_type'(60'({$urandom, $urandom}));
      w.mode         = MODE_ADJUST;
      w.field_select = sel;
      w.delta        = amount;
      return w;
   endfunction

   // mostly well-formed loads and small adjusts, with some raw noise
   function automatic req_type random_word();
      req_type w;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         w = load_word(to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
                       to_bcd($urandom_range(23)), to_bcd($urandom_range(1, 31)),
                       to_bcd($urandom_range(1, 12)), to_bcd($urandom_range(99)));
         // bits above the masks are don't-care on a load
         w.minutes_reg[7]   = 1'($urandom_range(1));
         w.hours_reg[7:6]   = 2'($urandom_range(3));
         w.days_reg[7:6]    = 2'($urandom_range(3));
         w.months_reg[7:5]  = 3'($urandom_range(7));
      end else if (pick < 42) begin
         w = load_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)));
         if (pick < 35) w.seconds_reg = w.seconds_reg | OSC_STOP_MASK;
      end else if (pick < 80) begin
         w = adjust_word(3'($urandom_range(7)), 8'($urandom_range(6) - 3));
      end else begin
         w = adjust_word(3'($urandom_range(7)), 8'($urandom_range(255)));
      end
      return w;
   endfunction

   task automatic wait_for_drain();
      while (pending_words.size() != 0 || req_valid || calendar_expect.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      logic    nxt_valid;
      req_type nxt_word;
      nxt_valid = req_valid;
      nxt_word  = req_word;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         nxt_valid = 1'b0;
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt_valid = 1'b1;
            nxt_word  = pending_words.pop_front();
         end
      end
      req_valid <= nxt_valid;
      req_word  <= nxt_word;
   end

   always @(negedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(99) < stall_pct);
   end

   // result monitor and request capture
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (calendar_expect.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word, expected none, got %h", $time, rsp_word);
            end else begin
               want = calendar_expect.pop_front();
               check_field("year_out",    want.year_out,    rsp_word.year_out);
               check_field("month_out",   want.month_out,   rsp_word.month_out);
               check_field("day_out",     want.day_out,     rsp_word.day_out);
               check_field("hour_out",    want.hour_out,    rsp_word.hour_out);
               check_field("minute_out",  want.minute_out,  rsp_word.minute_out);
               check_field("second_out",  want.second_out,  rsp_word.second_out);
               check_field("in_range",    want.in_range,    rsp_word.in_range);
               check_field("load_status", want.load_status, rsp_word.load_status);
            end
         end
         if (req_valid && !req_stall) advance_calendar(req_word);
      end
   end

   initial begin
      #2_000_000;
      $display("date_time_set_and_decode regression: fail");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int i;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      rsp_stall     = 1'b0;
      req_taken     = 1'b0;
      long_hold     = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      error_count   = 0;
      calendar_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      pending_words.push_back(adjust_word(FIELD_NONE_A, 8'd0));
      pending_words.push_back(load_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_words.push_back(load_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      pending_words.push_back(load_word(8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      pending_words.push_back(adjust_word(FIELD_MINUTE, 8'd0));   // 85 wraps to 25
      pending_words.push_back(adjust_word(FIELD_HOUR, 8'sd127));
      pending_words.push_back(adjust_word(FIELD_DAY, -8'sd128));  // bad month: 31 days
      pending_words.push_back(adjust_word(FIELD_MONTH, -8'sd128));
      pending_words.push_back(adjust_word(FIELD_YEAR, 8'sd127));
      pending_words.push_back(adjust_word(FIELD_NONE_B, -8'sd1));
      pending_words.push_back(load_word(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00));
      pending_words.push_back(adjust_word(FIELD_YEAR, 8'sd1));    // 29 Feb cut to 28
      pending_words.push_back(adjust_word(FIELD_YEAR, -8'sd1));
      pending_words.push_back(adjust_word(FIELD_DAY, 8'sd1));
      pending_words.push_back(adjust_word(FIELD_DAY, 8'sd1));     // wraps to 1
      pending_words.push_back(load_word(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'hA0));
      pending_words.push_back(adjust_word(FIELD_NONE_C, 8'd0));   // 2100 is no leap year
      pending_words.push_back(load_word(8'h30, 8'h15, 8'h12, 8'h31, 8'h80, 8'h24));
      pending_words.push_back(adjust_word(FIELD_NONE_A, 8'd0));
      pending_words.push_back(load_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h10));
      pending_words.push_back(adjust_word(FIELD_NONE_C, 8'd0));   // day 0 raised to 1
      pending_words.push_back(adjust_word(FIELD_MINUTE, -8'sd128));
      pending_words.push_back(adjust_word(FIELD_HOUR, -8'sd1));
      pending_words.push_back(load_word(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
      pending_words.push_back(adjust_word(FIELD_YEAR, 8'sd1));    // 2099 wraps to 2000
      wait_for_drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
         endcase
         for (i = 0; i < 230; i++) pending_words.push_back(random_word());
         if (phase == 0) begin
            // receiver holds off while words keep coming, so the block backs up
            long_hold = 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         // sender waits until every result is back before going on
         wait_for_drain();
         for (i = 0; i < 230; i++) pending_words.push_back(random_word());
         wait_for_drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("date_time_set_and_decode regression: pass");
      else
         $display("date_time_set_and_decode regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/dtsd_pkg.sv
hw/rtl/date_time_set_and_decode.sv
tb/sv/tb_top.sv
